// ===== design/pfb_pkg.sv =====
// Shared constants, request codes and controller/datapath interface types for the blitter.
`timescale 1ns / 1ps
package pfb_pkg;

  localparam int SCREEN_WIDTH  = 84;
  localparam int SCREEN_HEIGHT = 48;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int FB_BYTES      = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(FB_BYTES);
  localparam int PAGE_W        = $clog2(PAGE_COUNT + 1);
  localparam int COORD_W       = 12;

  localparam logic [2:0] REQ_SET  = 3'd0;
  localparam logic [2:0] REQ_CLR  = 3'd1;
  localparam logic [2:0] REQ_BLIT = 3'd2;
  localparam logic [2:0] REQ_WIPE = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;

  typedef struct packed {
    logic accept;
    logic coord;
    logic plan;
    logic rd_hi;
    logic wr_en;
    logic wr_hi;
    logic cap_read;
    logic clr_step;
  } pfb_cmd_t;

  typedef struct packed {
    logic is_wipe;
    logic need0;
    logic need1;
    logic clr_last;
  } pfb_sts_t;

endpackage

// ===== design/pfb_ctrl.sv =====
// Sequencing state machine: accept, coordinate and plan stages, read-modify-write, clear sweep.
`timescale 1ns / 1ps
module pfb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pfb_pkg::pfb_sts_t sts,
  output pfb_pkg::pfb_cmd_t cmd,
  output logic             busy,
  output logic             out_valid
);
  import pfb_pkg::*;

  typedef enum logic [2:0] {
    ST_WIPE, ST_IDLE, ST_COORD, ST_PLAN, ST_RD0, ST_WR0, ST_WR1
  } state_t;

  state_t state_r;
  logic   report_r;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          if (start) state_r <= ST_COORD;
        end
        ST_COORD: state_r <= ST_PLAN;
        ST_PLAN: begin
          if (sts.is_wipe) begin
            state_r  <= ST_WIPE;
            report_r <= 1'b1;
          end else begin
            state_r <= ST_RD0;
          end
        end
        ST_RD0: state_r <= ST_WR0;
        ST_WR0: begin
          if (sts.need1) begin
            state_r <= ST_WR1;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_WR1: begin
          state_r <= ST_IDLE;
        end
        ST_WIPE: begin
          if (sts.clr_last) begin
            state_r  <= ST_IDLE;
            report_r <= 1'b0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE:  cmd.accept = start;
      ST_COORD: cmd.coord  = 1'b1;
      ST_PLAN:  cmd.plan   = 1'b1;
      ST_WR0: begin
        cmd.wr_en     = sts.need0;
        cmd.cap_read  = 1'b1;
        cmd.rd_hi     = 1'b1;
        out_valid_nxt = !sts.need1;
      end
      ST_WR1: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_hi     = 1'b1;
        out_valid_nxt = 1'b1;
      end
      ST_WIPE: begin
        cmd.clr_step  = 1'b1;
        out_valid_nxt = sts.clr_last && report_r;
      end
      default: begin
        cmd           = '0;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/pfb_datapath.sv =====
// Request registers, bitmap counters, page address and mask planning, and the frame buffer memory.
`timescale 1ns / 1ps
module pfb_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  pfb_pkg::pfb_cmd_t cmd,
  output pfb_pkg::pfb_sts_t sts,
  input  logic [2:0]        in_req_type,
  input  logic signed [8:0] in_pos_x,
  input  logic signed [8:0] in_pos_y,
  input  logic [7:0]        in_bitmap_byte,
  input  logic [7:0]        in_width_px,
  input  logic [7:0]        in_height_px,
  input  logic              in_centred,
  input  logic              in_first_byte,
  input  logic [8:0]        in_read_address,
  output logic [7:0]        out_read_data,
  output logic              out_clipped
);
  import pfb_pkg::*;

  localparam logic signed [COORD_W-1:0] XLIM = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] YLIM = COORD_W'(SCREEN_HEIGHT);

  // bitmap counters
  logic [7:0] cc_r, cc_nxt;
  logic [4:0] pr_r, pr_nxt;

  // accepted request
  logic [2:0]        q_op_r;
  logic signed [8:0] q_x_r, q_y_r;
  logic [7:0]        q_w_r, q_h_r;
  logic              q_ctr_r;
  logic [7:0]        q_cc_r;
  logic [4:0]        q_pr_r;
  logic [7:0]        q_bits_r;
  logic [8:0]        q_raddr_r;

  // coordinate stage
  logic signed [COORD_W-1:0] px_r, py_r;

  // plan stage
  logic [ADDR_W-1:0] a0_r, a1_r;
  logic [7:0]        and0_r, or0_r, and1_r, or1_r;
  logic              need0_r, need1_r, clip_r, rdok_r;
  logic [7:0]        res_data_r;

  // memory
  logic [7:0]        mem [FB_BYTES];
  logic [7:0]        mem_q;
  logic [ADDR_W-1:0] clr_addr_r;

  // accept-side decode
  logic       blit_in;
  logic [7:0] cc_e;
  logic [4:0] pr_e;
  logic [5:0] pages;
  logic       skip;
  logic       full_row;
  logic [7:0] nmask;
  logic [7:0] bits_in;

  always_comb begin
    blit_in  = (in_req_type == REQ_BLIT);
    cc_e     = in_first_byte ? 8'd0 : cc_r;
    pr_e     = in_first_byte ? 5'd0 : pr_r;
    pages    = 6'((9'(in_height_px) + 9'd7) >> 3);
    skip     = (in_width_px == 8'd0) || (cc_e >= in_width_px) || (6'(pr_e) >= pages);
    full_row = (9'({pr_e, 3'b000}) + 9'd8) <= 9'(in_height_px);
    nmask    = full_row ? 8'hFF : 8'((9'd1 << in_height_px[2:0]) - 9'd1);
    if (blit_in) begin
      bits_in = skip ? 8'h00 : (in_bitmap_byte & nmask);
    end else if (in_req_type == REQ_SET || in_req_type == REQ_CLR) begin
      bits_in = 8'h01;
    end else begin
      bits_in = 8'h00;
    end

    cc_nxt = cc_r;
    pr_nxt = pr_r;
    if (cmd.accept && blit_in) begin
      cc_nxt = cc_e;
      pr_nxt = pr_e;
      if (!skip) begin
        if ((9'(cc_e) + 9'd1) < 9'(in_width_px)) begin
          cc_nxt = cc_e + 8'd1;
        end else if ((6'(pr_e) + 6'd1) < pages) begin
          cc_nxt = 8'd0;
          pr_nxt = pr_e + 5'd1;
        end else begin
          cc_nxt = in_width_px;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= 8'd0;
      pr_r <= 5'd0;
    end else begin
      cc_r <= cc_nxt;
      pr_r <= pr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_op_r    <= in_req_type;
      q_x_r     <= in_pos_x;
      q_y_r     <= in_pos_y;
      q_w_r     <= in_width_px;
      q_h_r     <= in_height_px;
      q_ctr_r   <= blit_in && in_centred;
      q_cc_r    <= blit_in ? cc_e : 8'd0;
      q_pr_r    <= blit_in ? pr_e : 5'd0;
      q_bits_r  <= bits_in;
      q_raddr_r <= in_read_address;
    end
  end

  // coordinate stage: top-left corner plus counters
  logic signed [COORD_W-1:0] x0, y0, xoff, yoff, px, py;

  always_comb begin
    x0   = COORD_W'(q_x_r);
    y0   = COORD_W'(q_y_r);
    xoff = q_ctr_r ? $signed(COORD_W'(q_w_r[7:1])) : '0;
    yoff = q_ctr_r ? $signed(COORD_W'(q_h_r[7:1])) : '0;
    px   = x0 - xoff + $signed(COORD_W'(q_cc_r));
    py   = y0 - yoff + $signed(COORD_W'({q_pr_r, 3'b000}));
  end

  always_ff @(posedge clk) begin
    if (cmd.coord) begin
      px_r <= px;
      py_r <= py;
    end
  end

  // plan stage: per-bit screen check, page window, addresses
  logic signed [COORD_W-1:0] yi [8];
  logic [7:0]                inr;
  logic                      x_ok;
  logic [7:0]                drawn;
  logic [15:0]               win;
  logic signed [COORD_W-1:0] pg;
  logic [PAGE_W-1:0]         pg0, pg1;
  logic [ADDR_W-1:0]         xa, a0, a1, a0_sel;
  logic                      is_read, rd_ok, is_clr;

  always_comb begin
    x_ok = (px_r >= 0) && (px_r < XLIM);
    for (int i = 0; i < 8; i++) begin
      yi[i]  = py_r + $signed(COORD_W'(i));
      inr[i] = x_ok && (yi[i] >= 0) && (yi[i] < YLIM);
    end
    drawn   = q_bits_r & inr;
    win     = 16'({8'h00, drawn} << py_r[2:0]);
    pg      = py_r >>> 3;
    pg0     = pg[PAGE_W-1:0];
    pg1     = pg0 + PAGE_W'(1);
    xa      = ADDR_W'(px_r[7:0]);
    a0      = ADDR_W'(ADDR_W'(pg0) * ADDR_W'(SCREEN_WIDTH)) + xa;
    a1      = ADDR_W'(ADDR_W'(pg1) * ADDR_W'(SCREEN_WIDTH)) + xa;
    is_read = (q_op_r == REQ_READ);
    is_clr  = (q_op_r == REQ_CLR);
    rd_ok   = is_read && (32'(q_raddr_r) < FB_BYTES);
    if (is_read) begin
      a0_sel = rd_ok ? ADDR_W'(q_raddr_r) : '0;
    end else begin
      a0_sel = a0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      a0_r    <= a0_sel;
      a1_r    <= a1;
      and0_r  <= is_clr ? ~win[7:0] : 8'hFF;
      or0_r   <= is_clr ? 8'h00 : win[7:0];
      and1_r  <= is_clr ? ~win[15:8] : 8'hFF;
      or1_r   <= is_clr ? 8'h00 : win[15:8];
      need0_r <= |win[7:0];
      need1_r <= |win[15:8];
      clip_r  <= |(q_bits_r & ~inr);
      rdok_r  <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      res_data_r <= 8'h00;
    end else if (cmd.cap_read) begin
      res_data_r <= rdok_r ? mem_q : 8'h00;
    end
  end

  // frame buffer: one write and one registered read per cycle
  logic              we;
  logic [ADDR_W-1:0] wa, ra;
  logic [7:0]        wd;
  logic              clr_last;

  always_comb begin
    clr_last = (clr_addr_r == ADDR_W'(FB_BYTES - 1));
    we       = cmd.wr_en || cmd.clr_step;
    ra       = cmd.rd_hi ? a1_r : a0_r;
    if (cmd.clr_step) begin
      wa = clr_addr_r;
      wd = 8'h00;
    end else if (cmd.wr_hi) begin
      wa = a1_r;
      wd = (mem_q & and1_r) | or1_r;
    end else begin
      wa = a0_r;
      wd = (mem_q & and0_r) | or0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    mem_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + ADDR_W'(1);
    end
  end

  assign sts.is_wipe  = (q_op_r == REQ_WIPE);
  assign sts.need0    = need0_r;
  assign sts.need1    = need1_r;
  assign sts.clr_last = clr_last;

  assign out_read_data = res_data_r;
  assign out_clipped   = clip_r;

endmodule

// ===== design/page_framebuffer_blitter.sv =====
// Top level of the page-organized monochrome frame buffer blitter.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive in_* and raise start; the item is taken at a rising
//   edge with start high and busy low. busy stays high until the item is done.
//   Requests: set pixel, clear pixel, bitmap column byte, clear buffer, read byte.
//   Result channel: out_valid is high for exactly one cycle per item, with
//   out_read_data and out_clipped; the receiver cannot stall and must take it.
// Sequencing:
//   A pixel, bitmap or read item passes the coordinate, plan, read and write
//   states, plus a second write when a bitmap byte straddles two pages, and
//   then yields its strobe; start is taken again in the strobe cycle. A buffer
//   clear passes the coordinate and plan states and then the clearing sweep.
//   Each page costs a registered read and a write on the frame buffer's one read
//   and one write port, the second page's read overlapping the first page's write.
// Reset:
//   rst_n is synchronous, active low. After reset the block sweeps the buffer
//   to zero, one byte a cycle through all FB_BYTES bytes, with busy high and no result;
//   the bitmap counters restart at zero.
module page_framebuffer_blitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_req_type,
  input  logic signed [8:0] in_pos_x,
  input  logic signed [8:0] in_pos_y,
  input  logic [7:0]        in_bitmap_byte,
  input  logic [7:0]        in_width_px,
  input  logic [7:0]        in_height_px,
  input  logic              in_centred,
  input  logic              in_first_byte,
  input  logic [8:0]        in_read_address,
  output logic              out_valid,
  output logic [7:0]        out_read_data,
  output logic              out_clipped
);
  import pfb_pkg::*;

  pfb_cmd_t cmd;
  pfb_sts_t sts;

  pfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pfb_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_bitmap_byte  (in_bitmap_byte),
    .in_width_px     (in_width_px),
    .in_height_px    (in_height_px),
    .in_centred      (in_centred),
    .in_first_byte   (in_first_byte),
    .in_read_address (in_read_address),
    .out_read_data   (out_read_data),
    .out_clipped     (out_clipped)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_data == 8'h00 || !out_clipped))
    else $error("read data and clip flag both set");
`endif

endmodule
